>>> rtl/spm_pkg.sv
// Shared types, widths and elaboration-time tables for the stereo peak meter.
// Depends on nothing; every other file refers to it by scoped names.
`timescale 1ns / 1ps

package spm_pkg;

	localparam int MAX_METER_WIDTH = 64;

	localparam int PEAK_W = 16;
	localparam int TIME_W = 32;
	localparam int HOLD_W = 16;
	localparam int MW_W   = 7;
	localparam int DB_W   = 12;
	localparam int FILL_W = 10;
	localparam int CELL_W = 6;

	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;

	localparam logic [MW_W-1:0]   MW_RESET   = MW_W'(27);
	localparam logic [HOLD_W-1:0] HOLD_RESET = HOLD_W'(1500);

	localparam logic signed [DB_W-1:0] DB_ZERO = -12'sd2000;
	// dB of the bottom of the bar, in tenths
	localparam int DB_FLOOR = 600;

	// log estimate: octave offset plus mantissa term, EST_FRAC fraction bits
	localparam int MSB_W    = $clog2(PEAK_W);
	localparam int EST_FRAC = 8;
	localparam int EST_W    = 19;
	localparam int DEST_W   = EST_W - EST_FRAC;
	localparam int MANT_IDX = 8;
	localparam int MANT_W   = 14;

	// threshold ROM: smallest magnitude that reaches each tenth of a dB
	localparam int DB_LO     = -905;
	localparam int DB_HI     = 62;
	localparam int THR_DEPTH = DB_HI - DB_LO + 1;
	localparam int THR_IDX_W = $clog2(THR_DEPTH);
	localparam int THR_W     = PEAK_W + 1;
	localparam int THR_OFS   = 1 - DB_LO;

	// scale steps for the table builders
	localparam real TENTHS_STEP = 1.0 / 200.0;
	localparam real MANT_STEP   = 1.0 / real'(1 << MANT_IDX);

	// floor(p/75) as (p * RECIP) >> RECIP_SHIFT, exact for p below 2^16
	localparam int FILL_DIV    = DB_FLOOR / 8;
	localparam int RECIP_SHIFT = 23;
	localparam int RECIP       = ((1 << RECIP_SHIFT) + FILL_DIV - 1) / FILL_DIV;
	localparam int RECIP_W     = 17;
	localparam int PROD_W      = PEAK_W;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_METER_WIDTH,
		REG_HOLD_TIME
	} cfg_reg_t;

	typedef struct packed {
		logic s2;
		logic s3;
		logic s4;
		logic s5;
	} stage_en_t;

	typedef logic [THR_DEPTH-1:0][THR_W-1:0] thr_tbl_t;
	typedef logic [PEAK_W-1:0][EST_W-1:0]    oct_tbl_t;
	typedef logic [(1<<MANT_IDX)-1:0][MANT_W-1:0] mant_tbl_t;

	function automatic thr_tbl_t build_thr_tbl();
		thr_tbl_t tbl;
		real      r;
		for (int i = 0; i < THR_DEPTH; i++) begin
			r = $ceil(32768.0 * $pow(10.0, real'(i + DB_LO) * TENTHS_STEP));
			tbl[i] = THR_W'($rtoi(r));
		end
		return tbl;
	endfunction

	// 200*log10(2)*(k-15), scaled and floored
	function automatic oct_tbl_t build_oct_tbl();
		oct_tbl_t tbl;
		real      r;
		for (int k = 0; k < PEAK_W; k++) begin
			r = $floor(real'(1 << EST_FRAC) * 200.0 * $log10(2.0) * real'(k - (PEAK_W - 1)));
			tbl[k] = EST_W'($rtoi(r));
		end
		return tbl;
	endfunction

	// 200*log10(1 + m/256), scaled and floored
	function automatic mant_tbl_t build_mant_tbl();
		mant_tbl_t tbl;
		real       r;
		for (int m = 0; m < (1 << MANT_IDX); m++) begin
			r = $floor(real'(1 << EST_FRAC) * 200.0 *
				$log10(1.0 + real'(m) * MANT_STEP));
			tbl[m] = MANT_W'($rtoi(r));
		end
		return tbl;
	endfunction

endpackage

>>> rtl/spm_if.sv
// Channel interfaces of the stereo peak meter: peak input, level output,
// configuration writes. Depends on spm_pkg.
`timescale 1ns / 1ps

interface spm_in_if;
	logic                             valid;
	logic                             ready;
	logic [spm_pkg::PEAK_W-1:0]       peak_left;
	logic [spm_pkg::PEAK_W-1:0]       peak_right;
	logic [spm_pkg::TIME_W-1:0]       now_ms;

	modport source (output valid, peak_left, peak_right, now_ms, input ready);
	modport sink   (input valid, peak_left, peak_right, now_ms, output ready);
endinterface

interface spm_out_if;
	logic                             valid;
	logic                             ready;
	logic signed [spm_pkg::DB_W-1:0]  level_db_left;
	logic signed [spm_pkg::DB_W-1:0]  level_db_right;
	logic signed [spm_pkg::DB_W-1:0]  held_db_left;
	logic signed [spm_pkg::DB_W-1:0]  held_db_right;
	logic [spm_pkg::FILL_W-1:0]       fill_eighths_left;
	logic [spm_pkg::FILL_W-1:0]       fill_eighths_right;
	logic [spm_pkg::CELL_W-1:0]       marker_cell_left;
	logic [spm_pkg::CELL_W-1:0]       marker_cell_right;

	modport source (output valid, level_db_left, level_db_right, held_db_left, held_db_right,
		fill_eighths_left, fill_eighths_right, marker_cell_left, marker_cell_right,
		input ready);
	modport sink   (input valid, level_db_left, level_db_right, held_db_left, held_db_right,
		fill_eighths_left, fill_eighths_right, marker_cell_left, marker_cell_right,
		output ready);
endinterface

interface spm_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [spm_pkg::CFG_IDX_W-1:0]    index;
	logic [spm_pkg::CFG_DATA_W-1:0]   data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/spm_db_conv.sv
// Magnitude to tenths of a dB: log estimate from octave and mantissa tables,
// then one threshold ROM compare fixes the floor. Depends on spm_pkg.
`timescale 1ns / 1ps

module spm_db_conv (
	input  logic                              clk,
	input  spm_pkg::stage_en_t                en,
	input  logic [spm_pkg::PEAK_W-1:0]        peak_s1,
	output logic signed [spm_pkg::DB_W-1:0]   level_db_s3
);

	localparam spm_pkg::thr_tbl_t  THR_TBL  = spm_pkg::build_thr_tbl();
	localparam spm_pkg::oct_tbl_t  OCT_TBL  = spm_pkg::build_oct_tbl();
	localparam spm_pkg::mant_tbl_t MANT_TBL = spm_pkg::build_mant_tbl();

	logic [spm_pkg::MSB_W-1:0]          msb;
	logic [spm_pkg::PEAK_W-1:0]         mant;
	logic [spm_pkg::MANT_IDX-1:0]       mant_idx;
	logic [spm_pkg::EST_W-1:0]          f_est;
	logic signed [spm_pkg::DEST_W-1:0]  d_est;
	logic [spm_pkg::DEST_W:0]           idx_full;
	logic [spm_pkg::THR_IDX_W-1:0]      thr_idx;

	logic [spm_pkg::THR_W-1:0]          thr_s2;
	logic signed [spm_pkg::DEST_W-1:0]  d_est_s2;
	logic [spm_pkg::PEAK_W-1:0]         peak_s2;
	logic signed [spm_pkg::DEST_W-1:0]  d_up;

	always_comb begin
		msb = '0;
		for (int i = 0; i < spm_pkg::PEAK_W; i++) begin
			if (peak_s1[i]) begin
				msb = spm_pkg::MSB_W'(i);
			end
		end
	end

	assign mant     = peak_s1 << (spm_pkg::MSB_W'(spm_pkg::PEAK_W - 1) - msb);
	assign mant_idx = mant[spm_pkg::PEAK_W-2 -: spm_pkg::MANT_IDX];

	// minus one LSB keeps the estimate at or below the true log
	assign f_est = OCT_TBL[msb]
		+ {{(spm_pkg::EST_W-spm_pkg::MANT_W){1'b0}}, MANT_TBL[mant_idx]}
		- spm_pkg::EST_W'(1);
	assign d_est    = f_est[spm_pkg::EST_W-1:spm_pkg::EST_FRAC];
	// true level is d_est or d_est+1: fetch the threshold of d_est+1
	assign idx_full = {d_est[spm_pkg::DEST_W-1], d_est} + (spm_pkg::DEST_W+1)'(spm_pkg::THR_OFS);
	assign thr_idx  = idx_full[spm_pkg::THR_IDX_W-1:0];

	always_ff @(posedge clk) begin
		if (en.s2) begin
			thr_s2   <= THR_TBL[thr_idx];
			d_est_s2 <= d_est;
			peak_s2  <= peak_s1;
		end
	end

	assign d_up = d_est_s2 + spm_pkg::DEST_W'(1);

	always_ff @(posedge clk) begin
		if (en.s3) begin
			if (peak_s2 == '0) begin
				level_db_s3 <= spm_pkg::DB_ZERO;
			end else if ({1'b0, peak_s2} >= thr_s2) begin
				level_db_s3 <= {d_up[spm_pkg::DEST_W-1], d_up};
			end else begin
				level_db_s3 <= {d_est_s2[spm_pkg::DEST_W-1], d_est_s2};
			end
		end
	end

endmodule

>>> rtl/spm_bar_scale.sv
// Tenths of a dB on a -60..0 dB bar: fill in eighths from the level, marker cell
// from the held level. Two stages: scale by the width, then divide by a reciprocal.
// Depends on spm_pkg.
`timescale 1ns / 1ps

module spm_bar_scale (
	input  logic                              clk,
	input  spm_pkg::stage_en_t                en,
	input  logic [spm_pkg::MW_W-1:0]          width,
	input  logic signed [spm_pkg::DB_W-1:0]   level_db,
	input  logic signed [spm_pkg::DB_W-1:0]   held_db,
	output logic [spm_pkg::FILL_W-1:0]        fill_s5,
	output logic [spm_pkg::CELL_W-1:0]        cell_s5
);

	logic signed [spm_pkg::DB_W:0]                 v_lvl, v_hld;
	logic [spm_pkg::FILL_W-1:0]                    pos_lvl, pos_hld;
	logic [spm_pkg::PROD_W-1:0]                    prod_lvl, prod_hld;
	logic [spm_pkg::PROD_W-1:0]                    prod_lvl_s4, prod_hld_s4;
	logic [spm_pkg::PROD_W+spm_pkg::RECIP_W-1:0]   quot_lvl, quot_hld;
	logic [spm_pkg::FILL_W-1:0]                    eighths_lvl, eighths_hld;
	logic [spm_pkg::FILL_W-1:0]                    w8;

	assign v_lvl   = {level_db[spm_pkg::DB_W-1], level_db}
		+ (spm_pkg::DB_W+1)'(spm_pkg::DB_FLOOR);
	assign v_hld   = {held_db[spm_pkg::DB_W-1], held_db}
		+ (spm_pkg::DB_W+1)'(spm_pkg::DB_FLOOR);
	assign pos_lvl = (v_lvl > 0) ? v_lvl[spm_pkg::FILL_W-1:0] : '0;
	assign pos_hld = (v_hld > 0) ? v_hld[spm_pkg::FILL_W-1:0] : '0;
	assign prod_lvl = spm_pkg::PROD_W'(pos_lvl) * spm_pkg::PROD_W'(width);
	assign prod_hld = spm_pkg::PROD_W'(pos_hld) * spm_pkg::PROD_W'(width);

	always_ff @(posedge clk) begin
		if (en.s4) begin
			prod_lvl_s4 <= prod_lvl;
			prod_hld_s4 <= prod_hld;
		end
	end

	assign quot_lvl = (spm_pkg::PROD_W+spm_pkg::RECIP_W)'(prod_lvl_s4)
		* (spm_pkg::PROD_W+spm_pkg::RECIP_W)'(spm_pkg::RECIP);
	assign quot_hld = (spm_pkg::PROD_W+spm_pkg::RECIP_W)'(prod_hld_s4)
		* (spm_pkg::PROD_W+spm_pkg::RECIP_W)'(spm_pkg::RECIP);
	assign eighths_lvl = quot_lvl[spm_pkg::RECIP_SHIFT +: spm_pkg::FILL_W];
	assign eighths_hld = quot_hld[spm_pkg::RECIP_SHIFT +: spm_pkg::FILL_W];
	assign w8          = {width, 3'b000};

	// cell = floor(eighths/8); at or past the full bar it sits on the last cell
	always_ff @(posedge clk) begin
		if (en.s5) begin
			fill_s5 <= (eighths_lvl > w8) ? w8 : eighths_lvl;
			cell_s5 <= (eighths_hld >= w8) ? spm_pkg::CELL_W'(width - spm_pkg::MW_W'(1))
				: eighths_hld[3 +: spm_pkg::CELL_W];
		end
	end

endmodule

>>> rtl/stereo_peak_hold_level_meter.sv
// Stereo peak-hold level meter top level: hold tracking, stage control,
// configuration registers. Depends on spm_pkg, spm_if, spm_db_conv, spm_bar_scale.
//
//  port     | dir  | moves per transaction
//  ---------+------+---------------------------------------------------------
//  samples  | sink | peak_left, peak_right, now_ms
//  levels   | src  | level/held dB, bar fill in eighths, marker cell, per side
//  cfg      | sink | index (0 meter_width, 1 hold_time_ms), data
//
// One transaction per cycle while levels.ready is high; a result passes the input
// registers, the registered threshold ROM read, the dB compare, the two scaling
// multiplies. Each stage advances when the next one is empty or moving, so
// bubbles close up while a result waits. Reset clears the held peaks and
// their timestamps and loads meter_width 27, hold_time_ms 1500; no init pass.
`timescale 1ns / 1ps

module stereo_peak_hold_level_meter (
	input  logic              clk,
	input  logic              arst_n,
	spm_in_if.sink            samples,
	spm_out_if.source         levels,
	spm_cfg_if.sink           cfg
);

	logic [spm_pkg::MW_W-1:0]        meter_width_q;
	logic [spm_pkg::HOLD_W-1:0]      hold_time_q;
	logic [spm_pkg::MW_W-1:0]        width;

	logic [spm_pkg::PEAK_W-1:0]      held_peak_l_q, held_peak_r_q;
	logic [spm_pkg::TIME_W-1:0]      held_since_l_q, held_since_r_q;
	logic signed [spm_pkg::DB_W-1:0] held_db_l_q, held_db_r_q;

	logic                            v1_q, v2_q, v3_q, v4_q, v5_q;
	logic                            en1, en2, en3, en4, en5;
	spm_pkg::stage_en_t              en;
	logic                            in_fire;

	logic [spm_pkg::TIME_W-1:0]      age_l, age_r;
	logic                            take_l, take_r;

	logic [spm_pkg::PEAK_W-1:0]      peak_l_s1, peak_r_s1;
	logic                            take_l_s1, take_r_s1;
	logic                            take_l_s2, take_r_s2;
	logic                            take_l_s3, take_r_s3;
	logic signed [spm_pkg::DB_W-1:0] level_l_s3, level_r_s3;
	logic signed [spm_pkg::DB_W-1:0] held_db_l, held_db_r;
	logic signed [spm_pkg::DB_W-1:0] level_l_s4, level_r_s4, held_l_s4, held_r_s4;
	logic signed [spm_pkg::DB_W-1:0] level_l_s5, level_r_s5, held_l_s5, held_r_s5;
	logic [spm_pkg::FILL_W-1:0]      fill_l_s5, fill_r_s5;
	logic [spm_pkg::CELL_W-1:0]      cell_l_s5, cell_r_s5;

	// ---- configuration ----
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			meter_width_q <= spm_pkg::MW_RESET;
			hold_time_q   <= spm_pkg::HOLD_RESET;
		end else if (cfg.valid) begin
			unique case (spm_pkg::cfg_reg_t'(cfg.index))
				spm_pkg::REG_METER_WIDTH: meter_width_q <= cfg.data[spm_pkg::MW_W-1:0];
				spm_pkg::REG_HOLD_TIME:   hold_time_q   <= cfg.data;
				default: ;
			endcase
		end
	end

	always_comb begin
		if (meter_width_q == '0) begin
			width = spm_pkg::MW_W'(1);
		end else if (meter_width_q > spm_pkg::MW_W'(spm_pkg::MAX_METER_WIDTH)) begin
			width = spm_pkg::MW_W'(spm_pkg::MAX_METER_WIDTH);
		end else begin
			width = meter_width_q;
		end
	end

	// ---- stage control ----
	assign en5 = !v5_q || levels.ready;
	assign en4 = !v4_q || en5;
	assign en3 = !v3_q || en4;
	assign en2 = !v2_q || en3;
	assign en1 = !v1_q || en2;
	assign en  = '{s2: en2, s3: en3, s4: en4, s5: en5};

	assign samples.ready = en1;
	assign in_fire       = samples.valid && en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
			v2_q <= 1'b0;
			v3_q <= 1'b0;
			v4_q <= 1'b0;
			v5_q <= 1'b0;
		end else begin
			if (en1)   v1_q <= samples.valid;
			if (en.s2) v2_q <= v1_q;
			if (en.s3) v3_q <= v2_q;
			if (en.s4) v4_q <= v3_q;
			if (en.s5) v5_q <= v4_q;
		end
	end

	// ---- hold decision at accept ----
	assign age_l  = samples.now_ms - held_since_l_q;
	assign age_r  = samples.now_ms - held_since_r_q;
	assign take_l = (samples.peak_left >= held_peak_l_q)
		|| (age_l > spm_pkg::TIME_W'(hold_time_q));
	assign take_r = (samples.peak_right >= held_peak_r_q)
		|| (age_r > spm_pkg::TIME_W'(hold_time_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_peak_l_q  <= '0;
			held_peak_r_q  <= '0;
			held_since_l_q <= '0;
			held_since_r_q <= '0;
		end else if (in_fire) begin
			if (take_l) begin
				held_peak_l_q  <= samples.peak_left;
				held_since_l_q <= samples.now_ms;
			end
			if (take_r) begin
				held_peak_r_q  <= samples.peak_right;
				held_since_r_q <= samples.now_ms;
			end
		end
	end

	// ---- payload stages ----
	always_ff @(posedge clk) begin
		if (en1) begin
			peak_l_s1 <= samples.peak_left;
			peak_r_s1 <= samples.peak_right;
			take_l_s1 <= take_l;
			take_r_s1 <= take_r;
		end
		if (en.s2) begin
			take_l_s2 <= take_l_s1;
			take_r_s2 <= take_r_s1;
		end
		if (en.s3) begin
			take_l_s3 <= take_l_s2;
			take_r_s3 <= take_r_s2;
		end
		if (en.s4) begin
			level_l_s4 <= level_l_s3;
			level_r_s4 <= level_r_s3;
			held_l_s4  <= held_db_l;
			held_r_s4  <= held_db_r;
		end
		if (en.s5) begin
			level_l_s5 <= level_l_s4;
			level_r_s5 <= level_r_s4;
			held_l_s5  <= held_l_s4;
			held_r_s5  <= held_r_s4;
		end
	end

	spm_db_conv u_conv_l (
		.clk         (clk),
		.en          (en),
		.peak_s1     (peak_l_s1),
		.level_db_s3 (level_l_s3)
	);

	spm_db_conv u_conv_r (
		.clk         (clk),
		.en          (en),
		.peak_s1     (peak_r_s1),
		.level_db_s3 (level_r_s3)
	);

	// held dB follows the held peak in item order: new level when taken
	assign held_db_l = take_l_s3 ? level_l_s3 : held_db_l_q;
	assign held_db_r = take_r_s3 ? level_r_s3 : held_db_r_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_db_l_q <= spm_pkg::DB_ZERO;
			held_db_r_q <= spm_pkg::DB_ZERO;
		end else if (en.s4 && v3_q) begin
			held_db_l_q <= held_db_l;
			held_db_r_q <= held_db_r;
		end
	end

	spm_bar_scale u_bar_l (
		.clk      (clk),
		.en       (en),
		.width    (width),
		.level_db (level_l_s3),
		.held_db  (held_db_l),
		.fill_s5  (fill_l_s5),
		.cell_s5  (cell_l_s5)
	);

	spm_bar_scale u_bar_r (
		.clk      (clk),
		.en       (en),
		.width    (width),
		.level_db (level_r_s3),
		.held_db  (held_db_r),
		.fill_s5  (fill_r_s5),
		.cell_s5  (cell_r_s5)
	);

	assign levels.valid              = v5_q;
	assign levels.level_db_left      = level_l_s5;
	assign levels.level_db_right     = level_r_s5;
	assign levels.held_db_left       = held_l_s5;
	assign levels.held_db_right      = held_r_s5;
	assign levels.fill_eighths_left  = fill_l_s5;
	assign levels.fill_eighths_right = fill_r_s5;
	assign levels.marker_cell_left   = cell_l_s5;
	assign levels.marker_cell_right  = cell_r_s5;

	// ---- checks ----
	// a held peak is never below the peak of the same transaction
	a_held_ge_level_l: assert property (@(posedge clk) disable iff (!arst_n)
		levels.valid |-> levels.held_db_left >= levels.level_db_left)
		else $error("left held level below current level");

	a_held_ge_level_r: assert property (@(posedge clk) disable iff (!arst_n)
		levels.valid |-> levels.held_db_right >= levels.level_db_right)
		else $error("right held level below current level");

	a_take_louder: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && (samples.peak_left >= held_peak_l_q)
		|=> held_peak_l_q == $past(samples.peak_left))
		else $error("louder left peak not taken into hold");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		levels.valid |-> (levels.fill_eighths_left <= {width, 3'b000})
			&& (levels.fill_eighths_right <= {width, 3'b000}))
		else $error("bar fill past full width");

	a_marker_bound: assert property (@(posedge clk) disable iff (!arst_n)
		levels.valid |-> (spm_pkg::MW_W'(levels.marker_cell_left) < width)
			&& (spm_pkg::MW_W'(levels.marker_cell_right) < width))
		else $error("hold marker past last cell");

endmodule

>>> tb/stereo_peak_hold_level_meter_tb.sv
// Testbench for stereo_peak_hold_level_meter: directed and random peak pairs
// under random stalls, checked against a scoreboard with its own meter math.
// Depends on spm_pkg, spm_if and the RTL top level.
`timescale 1ns / 1ps

typedef struct packed {
	logic [spm_pkg::PEAK_W-1:0] peak_left;
	logic [spm_pkg::PEAK_W-1:0] peak_right;
	logic [spm_pkg::TIME_W-1:0] now_ms;
} peak_sample_t;

typedef struct packed {
	logic signed [spm_pkg::DB_W-1:0] level_db_left;
	logic signed [spm_pkg::DB_W-1:0] level_db_right;
	logic signed [spm_pkg::DB_W-1:0] held_db_left;
	logic signed [spm_pkg::DB_W-1:0] held_db_right;
	logic [spm_pkg::FILL_W-1:0]      fill_eighths_left;
	logic [spm_pkg::FILL_W-1:0]      fill_eighths_right;
	logic [spm_pkg::CELL_W-1:0]      marker_cell_left;
	logic [spm_pkg::CELL_W-1:0]      marker_cell_right;
} meter_levels_t;

class meter_scoreboard;
	meter_levels_t                pending_levels[$];
	logic [spm_pkg::MW_W-1:0]     width_reg;
	logic [spm_pkg::HOLD_W-1:0]   hold_reg;
	logic [spm_pkg::PEAK_W-1:0]   held_l, held_r;
	logic [spm_pkg::TIME_W-1:0]   since_l, since_r;
	longint                       log2_ten;
	int                           errors;

	function new();
		width_reg = spm_pkg::MW_RESET;
		hold_reg  = spm_pkg::HOLD_RESET;
		held_l    = '0;
		held_r    = '0;
		since_l   = '0;
		since_r   = '0;
		errors    = 0;
		log2_ten  = longint'(log2_q48(10));
	endfunction

	// log2 in Q.48 by repeated squaring of the normalized mantissa
	function longint unsigned log2_q48(int unsigned v);
		int             msb;
		int             i;
		logic [63:0]    m;
		logic [127:0]   sq;
		longint unsigned frac;
		msb = 31;
		while (msb > 0 && v[msb] == 1'b0)
			msb--;
		m = 64'(v) << (62 - msb);
		frac = 0;
		for (i = 0; i < 48; i++) begin
			sq = 128'(m) * 128'(m);
			m = sq[125:62];
			frac = frac << 1;
			if (m[63]) begin
				m = m >> 1;
				frac = frac | 1;
			end
		end
		return (longint'(msb) << 48) | frac;
	endfunction

	// floor(200*log10(x/32768)), zero pinned to the bottom code
	function int tenths_db(int unsigned x);
		longint l, num, q;
		if (x == 0)
			return -2000;
		l = longint'(log2_q48(x)) - (longint'(15) << 48);
		num = 200 * l;
		q = num / log2_ten;
		if (num % log2_ten != 0 && num < 0)
			q--;
		return int'(q);
	endfunction

	function int meter_cells();
		if (width_reg == 0)
			return 1;
		if (width_reg > spm_pkg::MAX_METER_WIDTH)
			return spm_pkg::MAX_METER_WIDTH;
		return int'(width_reg);
	endfunction

	function int bar_fill(int db, int w);
		int v, e;
		v = db + spm_pkg::DB_FLOOR;
		if (v <= 0)
			return 0;
		e = (v * w * 8) / spm_pkg::DB_FLOOR;
		return (e > w * 8) ? w * 8 : e;
	endfunction

	function int hold_cell(int db, int w);
		int v, c;
		v = db + spm_pkg::DB_FLOOR;
		if (v <= 0)
			return 0;
		c = (v * w) / spm_pkg::DB_FLOOR;
		return (c > w - 1) ? w - 1 : c;
	endfunction

	function bit takes_peak(logic [15:0] peak, logic [15:0] held, logic [31:0] since,
		logic [31:0] now);
		logic [31:0] age;
		age = now - since;
		return (peak >= held) || (age > 32'(hold_reg));
	endfunction

	function void write_reg(spm_pkg::cfg_reg_t idx, logic [spm_pkg::CFG_DATA_W-1:0] d);
		case (idx)
			spm_pkg::REG_METER_WIDTH: width_reg = d[spm_pkg::MW_W-1:0];
			spm_pkg::REG_HOLD_TIME:   hold_reg  = d[spm_pkg::HOLD_W-1:0];
			default: ;
		endcase
	endfunction

	function void note_sample(peak_sample_t s);
		meter_levels_t e;
		int w, dl, dr, hl, hr;
		w = meter_cells();
		if (takes_peak(s.peak_left, held_l, since_l, s.now_ms)) begin
			held_l  = s.peak_left;
			since_l = s.now_ms;
		end
		if (takes_peak(s.peak_right, held_r, since_r, s.now_ms)) begin
			held_r  = s.peak_right;
			since_r = s.now_ms;
		end
		dl = tenths_db(s.peak_left);
		dr = tenths_db(s.peak_right);
		hl = tenths_db(held_l);
		hr = tenths_db(held_r);
		e.level_db_left      = dl[spm_pkg::DB_W-1:0];
		e.level_db_right     = dr[spm_pkg::DB_W-1:0];
		e.held_db_left       = hl[spm_pkg::DB_W-1:0];
		e.held_db_right      = hr[spm_pkg::DB_W-1:0];
		e.fill_eighths_left  = spm_pkg::FILL_W'(bar_fill(dl, w));
		e.fill_eighths_right = spm_pkg::FILL_W'(bar_fill(dr, w));
		e.marker_cell_left   = spm_pkg::CELL_W'(hold_cell(hl, w));
		e.marker_cell_right  = spm_pkg::CELL_W'(hold_cell(hr, w));
		pending_levels.push_back(e);
	endfunction

	function void cmp(string name, logic signed [31:0] exp_v, logic signed [31:0] act_v);
		if (exp_v !== act_v) begin
			$error("%s: expected %0d, got %0d", name, exp_v, act_v);
			errors++;
		end
	endfunction

	function void check_result(meter_levels_t a);
		meter_levels_t e;
		if (pending_levels.size() == 0) begin
			$error("result with no pending transaction");
			errors++;
			return;
		end
		e = pending_levels.pop_front();
		cmp("level_db_left", e.level_db_left, a.level_db_left);
		cmp("level_db_right", e.level_db_right, a.level_db_right);
		cmp("held_db_left", e.held_db_left, a.held_db_left);
		cmp("held_db_right", e.held_db_right, a.held_db_right);
		cmp("fill_eighths_left", e.fill_eighths_left, a.fill_eighths_left);
		cmp("fill_eighths_right", e.fill_eighths_right, a.fill_eighths_right);
		cmp("marker_cell_left", e.marker_cell_left, a.marker_cell_left);
		cmp("marker_cell_right", e.marker_cell_right, a.marker_cell_right);
	endfunction

	function int pending();
		return pending_levels.size();
	endfunction
endclass

module stereo_peak_hold_level_meter_tb;

	localparam int PHASES      = 7;
	localparam int PHASE_ITEMS = 270;

	logic clk = 1'b0;
	logic arst_n;

	spm_in_if  samples_if();
	spm_out_if levels_if();
	spm_cfg_if cfg_if();

	meter_scoreboard sb = new();

	bit long_stall_req = 1'b0;
	int sender_burst   = 0;

	// reset state, hold boundaries, time wrap, dB scale edges
	peak_sample_t directed_samples [20] = '{
		'{16'd0,     16'd0,     32'd0},
		'{16'd65535, 16'd32768, 32'd1},
		'{16'd1,     16'd32767, 32'd2},
		'{16'd32769, 16'd2,     32'd1501},
		'{16'd100,   16'd100,   32'd1502},
		'{16'd100,   16'd100,   32'd1502},
		'{16'd200,   16'd200,   32'hFFFF_FFFF},
		'{16'd100,   16'd100,   32'h0000_0005},
		'{16'd10,    16'd10,    32'hFFFF_FFF0},
		'{16'd32,    16'd33,    32'hFFFF_FFF1},
		'{16'd3,     16'd4,     32'h7FFF_FFFF},
		'{16'd16384, 16'd23170, 32'h8000_0000},
		'{16'd23171, 16'd46341, 32'h8000_0001},
		'{16'd65534, 16'd32767, 32'h8000_0002},
		'{16'd2,     16'd1,     32'h8000_0003},
		'{16'd0,     16'd65535, 32'h8000_0004},
		'{16'd32768, 16'd0,     32'h8000_0005},
		'{16'd4096,  16'd8192,  32'h8000_0006},
		'{16'd11,    16'd12,    32'hAAAA_5555},
		'{16'd1000,  16'd30000, 32'h5555_AAAA}
	};

	stereo_peak_hold_level_meter uut (
		.clk    (clk),
		.arst_n (arst_n),
		.samples(samples_if),
		.levels (levels_if),
		.cfg    (cfg_if)
	);

	always #5 clk = ~clk;

	initial begin
		#10_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n && levels_if.valid === 1'b1 && levels_if.ready === 1'b1)
			sb.check_result('{levels_if.level_db_left, levels_if.level_db_right,
				levels_if.held_db_left, levels_if.held_db_right,
				levels_if.fill_eighths_left, levels_if.fill_eighths_right,
				levels_if.marker_cell_left, levels_if.marker_cell_right});
	end

	// output side backpressure; one long hold-off per request from the driver
	initial begin
		int n;
		levels_if.ready = 1'b0;
		forever begin
			if (long_stall_req) begin
				long_stall_req = 1'b0;
				levels_if.ready <= 1'b0;
				repeat (300) @(posedge clk);
			end else if ($urandom_range(0, 99) < 25) begin
				n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
				levels_if.ready <= 1'b0;
				repeat (n) @(posedge clk);
			end
			levels_if.ready <= 1'b1;
			n = ($urandom_range(0, 7) == 0) ? 60 : $urandom_range(1, 12);
			repeat (n) @(posedge clk);
		end
	end

	// leaves valid high on return; the caller lowers it or sends again in the same step
	task automatic send_sample(peak_sample_t s);
		int gap, roll;
		roll = $urandom_range(0, 99);
		if (sender_burst > 0) begin
			sender_burst--;
			gap = 0;
		end else if (roll < 4) begin
			sender_burst = 50;
			gap = 0;
		end else begin
			gap = (roll < 55) ? 0 : (roll < 92) ? $urandom_range(1, 3) : $urandom_range(8, 40);
		end
		if (gap > 0) begin
			samples_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		samples_if.valid      <= 1'b1;
		samples_if.peak_left  <= s.peak_left;
		samples_if.peak_right <= s.peak_right;
		samples_if.now_ms     <= s.now_ms;
		do
			@(posedge clk);
		while (samples_if.ready !== 1'b1);
		sb.note_sample(s);
	endtask

	task automatic configure(logic [spm_pkg::CFG_DATA_W-1:0] width_data,
		logic [spm_pkg::CFG_DATA_W-1:0] hold_data);
		cfg_if.valid <= 1'b1;
		cfg_if.index <= spm_pkg::REG_METER_WIDTH;
		cfg_if.data  <= width_data;
		do
			@(posedge clk);
		while (cfg_if.ready !== 1'b1);
		sb.write_reg(spm_pkg::REG_METER_WIDTH, width_data);
		cfg_if.index <= spm_pkg::REG_HOLD_TIME;
		cfg_if.data  <= hold_data;
		do
			@(posedge clk);
		while (cfg_if.ready !== 1'b1);
		sb.write_reg(spm_pkg::REG_HOLD_TIME, hold_data);
		cfg_if.valid <= 1'b0;
	endtask

	task automatic drain();
		samples_if.valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// decaying and rising meter-like peaks with full-scale, silent, small and uniform noise mixed in
	function automatic logic [15:0] next_peak(logic [15:0] prev);
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 8)
			return 16'd0;
		if (roll < 14)
			case ($urandom_range(0, 3))
				0: return 16'd32768;
				1: return 16'd65535;
				2: return 16'd32767;
				default: return 16'd32769;
			endcase
		if (roll < 20)
			return 16'($urandom_range(1, 64));
		if (roll < 45)
			return 16'($urandom());
		if (roll < 75)
			return prev - 16'($urandom_range(0, int'(prev) / 8));
		return 16'($urandom_range(int'(prev), 65535));
	endfunction

	initial begin
		peak_sample_t s;
		logic [31:0]  now_cursor;
		int           roll;
		arst_n            = 1'b0;
		samples_if.valid  = 1'b0;
		samples_if.peak_left  = '0;
		samples_if.peak_right = '0;
		samples_if.now_ms     = '0;
		cfg_if.valid      = 1'b0;
		cfg_if.index      = spm_pkg::REG_METER_WIDTH;
		cfg_if.data       = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_samples[i])
			send_sample(directed_samples[i]);

		for (int p = 0; p < PHASES; p++) begin
			drain();
			case (p)
				0: ;  // reset settings
				1: configure(16'd1, 16'd0);
				2: configure(16'd64, 16'd65535);
				3: configure(16'hFF80, 16'd10);  // width 0 with upper bits set
				4: configure(16'h007F, 16'd250);
				5: configure({7'($urandom()), 2'b00, 7'd65}, 16'd3000);
				default: configure({9'($urandom()), 7'($urandom_range(1, 64))},
					16'($urandom()));
			endcase
			now_cursor   = $urandom();
			s.peak_left  = 16'($urandom());
			s.peak_right = 16'($urandom());
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				if ((p == 2 || p == 5) && k == PHASE_ITEMS / 2)
					long_stall_req = 1'b1;
				roll = $urandom_range(0, 99);
				if (roll < 65)
					now_cursor = now_cursor + 32'($urandom_range(0, 3));
				else if (roll < 85)
					now_cursor = now_cursor + 32'($urandom_range(0, 2 * int'(sb.hold_reg) + 2));
				else if (roll < 95)
					// land on the hold boundary, one side or the other
					now_cursor = (($urandom_range(0, 1) == 0) ? sb.since_l : sb.since_r) +
						32'(sb.hold_reg) + 32'($urandom_range(0, 1));
				else
					now_cursor = $urandom();
				s.peak_left  = next_peak(s.peak_left);
				s.peak_right = next_peak(s.peak_right);
				s.now_ms     = now_cursor;
				send_sample(s);
			end
		end

		drain();
		if (sb.errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end
endmodule

>>> files.f
rtl/spm_pkg.sv
rtl/spm_if.sv
rtl/spm_db_conv.sv
rtl/spm_bar_scale.sv
rtl/stereo_peak_hold_level_meter.sv
tb/stereo_peak_hold_level_meter_tb.sv
